FILE: hw/rtl/two_wire_link_byte_engine_top_assert.svh
// Assertion macros shared by the two-wire link RTL.
`ifndef TWO_WIRE_LINK_BYTE_ENGINE_TOP_ASSERT_SVH
`define TWO_WIRE_LINK_BYTE_ENGINE_TOP_ASSERT_SVH

// Condition must hold on every clock edge outside reset.
`define TWL_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent must hold on the same edge as the antecedent.
`define TWL_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold on the edge after the antecedent.
`define TWL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/twl_pkg.sv
// Types and constants of the two-wire link byte engine.
package twl_pkg;

   // command codes carried in the action field
   localparam logic [1:0] ACT_TICK  = 2'd0;
   localparam logic [1:0] ACT_SEND  = 2'd1;
   localparam logic [1:0] ACT_RECV  = 2'd2;
   localparam logic [1:0] ACT_ABORT = 2'd3;

   // result error codes
   localparam logic [1:0] ERR_NONE         = 2'd0;
   localparam logic [1:0] ERR_SEND_TIMEOUT = 2'd1;
   localparam logic [1:0] ERR_RECV_TIMEOUT = 2'd2;
   localparam logic [1:0] ERR_REFUSED      = 2'd3;

   // configuration register indexes
   localparam int unsigned CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TIMEOUT   = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BIT_DELAY = 1'd1;
   localparam int unsigned CFG_BITS = 16;
   localparam logic [CFG_BITS-1:0] TIMEOUT_RESET   = 16'd1000;
   localparam logic [CFG_BITS-1:0] BIT_DELAY_RESET = 16'd0;

   // bits per byte; bit counter must hold the value itself
   localparam logic [3:0] BITS_PER_BYTE = 4'd8;

   // entries between the front and the back
   localparam int unsigned QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] tx_byte;
      logic       last_in_transfer;
      logic       red_line;
      logic       white_line;
   } req_type;

   typedef struct packed {
      logic       pull_red_low;
      logic       pull_white_low;
      logic       busy_res;
      logic       byte_done;
      logic [7:0] rx_byte;
      logic [1:0] error_code;
   } rsp_type;

endpackage

FILE: hw/rtl/two_wire_link_byte_engine_top.sv
// Top level of the two-wire link byte engine: tick queue followed by the handshake engine.
//
// Each transaction on the req_ channel is one tick: the sampled red and white wire levels
// plus an optional command (send byte, receive byte, abort). Every tick produces exactly one
// rsp_ transaction with the wire drive for the next tick, busy, byte-done, the received byte
// and an error code. One tick is accepted per clock cycle while the queue has room and the
// engine is not held by a full result register and low rsp_ready. An accepted tick goes
// into the front queue, is then stepped by the engine and loads the result register. The
// engine steps its whole bit-handshake state once per tick. The two-entry queue and the result
// register let either side stall without stopping the other. Timeout and bit delay are set
// through the csr_ port; the user must write them only while no tick is outstanding, which
// the block itself does not enforce.

module two_wire_link_byte_engine_top #(
   parameter int unsigned COUNTER_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_en,
   input  logic [twl_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [twl_pkg::CFG_BITS-1:0]       csr_wdata,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  twl_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output twl_pkg::rsp_type                   rsp_data
);

   logic             q_valid;
   logic             q_ready;
   twl_pkg::req_type q_data;

   // front: tick queue
   twl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_data  (q_data)
   );

   // back: handshake engine
   twl_engine #(
      .COUNTER_BITS (COUNTER_BITS)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .in_valid     (q_valid),
      .in_ready     (q_ready),
      .in_data      (q_data),
      .out_valid    (rsp_valid),
      .out_ready    (rsp_ready),
      .out_data     (rsp_data)
   );

endmodule

FILE: hw/rtl/twl_queue.sv
// Front part: accepts tick transactions into a short queue for the engine.
`include "two_wire_link_byte_engine_top_assert.svh"

module twl_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  twl_pkg::req_type  in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output twl_pkg::req_type  out_data
);

   localparam int unsigned DEPTH    = twl_pkg::QUEUE_DEPTH;
   localparam int unsigned PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);
   localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(DEPTH);
   localparam logic [PTR_BITS-1:0] LAST_PTR   = PTR_BITS'(DEPTH - 1);

   twl_pkg::req_type    mem_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                push;
   logic                pop;

   assign in_ready  = (count_ff != FULL_COUNT);
   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

   `TWL_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= FULL_COUNT, "queue overfilled")
   `TWL_ASSERT_NEXT(a_fills_up, clock, reset, push && !pop && (count_ff == FULL_COUNT - 1'b1), !in_ready, "queue did not report full")

endmodule

FILE: hw/rtl/twl_engine.sv
// Back part: per-tick handshake engine, configuration registers and result register.
`include "two_wire_link_byte_engine_top_assert.svh"

module twl_engine #(
   parameter int unsigned COUNTER_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_en,
   input  logic [twl_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [twl_pkg::CFG_BITS-1:0]         csr_wdata,
   input  logic                                 in_valid,
   output logic                                 in_ready,
   input  twl_pkg::req_type                     in_data,
   output logic                                 out_valid,
   input  logic                                 out_ready,
   output twl_pkg::rsp_type                     out_data
);

   localparam int unsigned CFG_BITS = twl_pkg::CFG_BITS;
   localparam int unsigned CMP_BITS =
      ((COUNTER_BITS > CFG_BITS) ? COUNTER_BITS : CFG_BITS) + 1;
   localparam logic [COUNTER_BITS-1:0] CNT_MAX = {COUNTER_BITS{1'b1}};

   typedef enum logic [2:0] {
      PH_IDLE      = 3'd0,
      PH_SEND_A    = 3'd1,
      PH_SEND_B    = 3'd2,
      PH_RECV_WAIT = 3'd3,
      PH_RECV_ACK  = 3'd4,
      PH_DELAY     = 3'd5
   } phase_type;

   phase_type               phase_ff, phase_in;
   logic                    is_receive_ff, is_receive_in;
   logic [7:0]              shift_ff, shift_in;
   logic [3:0]              bit_index_ff, bit_index_in;
   logic [COUNTER_BITS-1:0] wait_count_ff, wait_count_in;
   logic [COUNTER_BITS-1:0] delay_count_ff, delay_count_in;
   logic                    current_last_ff, current_last_in;
   logic                    failed_ff, failed_in;
   logic [CFG_BITS-1:0]     timeout_ff;
   logic [CFG_BITS-1:0]     bit_delay_ff;
   twl_pkg::rsp_type        rsp_ff, rsp_in;
   logic                    rsp_valid_ff;
   logic                    fire;

   // one tick is stepped whenever the result register is free or drains
   assign in_ready  = !rsp_valid_ff || out_ready;
   assign fire      = in_valid && in_ready;
   assign out_valid = rsp_valid_ff;
   assign out_data  = rsp_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff   <= twl_pkg::TIMEOUT_RESET;
         bit_delay_ff <= twl_pkg::BIT_DELAY_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            twl_pkg::CSR_TIMEOUT:   timeout_ff   <= csr_wdata;
            twl_pkg::CSR_BIT_DELAY: bit_delay_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // tick step
   always_comb begin
      logic                cur;
      logic                done;
      logic                fail;
      logic                wait_hit;
      logic                delay_hit;
      logic                bit_end;
      logic [CFG_BITS-1:0] lim;
      logic [3:0]          next_index;
      logic [1:0]          err;
      logic [7:0]          rxb;

      phase_in        = phase_ff;
      is_receive_in   = is_receive_ff;
      shift_in        = shift_ff;
      bit_index_in    = bit_index_ff;
      wait_count_in   = wait_count_ff;
      delay_count_in  = delay_count_ff;
      current_last_in = current_last_ff;
      failed_in       = failed_ff;

      cur        = shift_ff[0];
      done       = 1'b0;
      fail       = 1'b0;
      bit_end    = 1'b0;
      err        = twl_pkg::ERR_NONE;
      rxb        = 8'd0;
      lim        = (timeout_ff == '0) ? CFG_BITS'(1) : timeout_ff;
      wait_hit   = (CMP_BITS'(wait_count_ff) + CMP_BITS'(1) >= CMP_BITS'(lim)) ||
                   (wait_count_ff == CNT_MAX);
      delay_hit  = (CMP_BITS'(delay_count_ff) + CMP_BITS'(1) >= CMP_BITS'(bit_delay_ff)) ||
                   (delay_count_ff == CNT_MAX);
      next_index = bit_index_ff + 4'd1;

      if (in_data.action == twl_pkg::ACT_ABORT) begin
         phase_in  = PH_IDLE;
         failed_in = 1'b0;
      end else if ((in_data.action == twl_pkg::ACT_SEND ||
                    in_data.action == twl_pkg::ACT_RECV) && phase_ff == PH_IDLE) begin
         if (failed_ff) begin
            // refuse bytes left over from a failed transfer
            done = 1'b1;
            err  = twl_pkg::ERR_REFUSED;
            if (in_data.last_in_transfer) begin
               failed_in = 1'b0;
            end
         end else begin
            is_receive_in   = (in_data.action == twl_pkg::ACT_RECV);
            shift_in        = is_receive_in ? 8'd0 : in_data.tx_byte;
            bit_index_in    = 4'd0;
            wait_count_in   = '0;
            current_last_in = in_data.last_in_transfer;
            phase_in        = is_receive_in ? PH_RECV_WAIT : PH_SEND_A;
         end
      end else begin
         unique case (phase_ff)
            PH_IDLE: ;
            PH_SEND_A: begin
               if (cur ? !in_data.red_line : !in_data.white_line) begin
                  wait_count_in = '0;
                  phase_in      = PH_SEND_B;
               end else if (wait_hit) begin
                  fail = 1'b1;
               end else begin
                  wait_count_in = wait_count_ff + 1'b1;
               end
            end
            PH_SEND_B: begin
               if (cur ? in_data.red_line : in_data.white_line) begin
                  bit_end = 1'b1;
               end else if (wait_hit) begin
                  fail = 1'b1;
               end else begin
                  wait_count_in = wait_count_ff + 1'b1;
               end
            end
            PH_RECV_WAIT: begin
               if (in_data.red_line && !in_data.white_line) begin
                  shift_in      = {1'b1, shift_ff[7:1]};
                  wait_count_in = '0;
                  phase_in      = PH_RECV_ACK;
               end else if (!in_data.red_line) begin
                  shift_in      = {1'b0, shift_ff[7:1]};
                  wait_count_in = '0;
                  phase_in      = PH_RECV_ACK;
               end else if (wait_hit) begin
                  fail = 1'b1;
               end else begin
                  wait_count_in = wait_count_ff + 1'b1;
               end
            end
            PH_RECV_ACK: begin
               if (shift_ff[7] ? in_data.white_line : in_data.red_line) begin
                  bit_end = 1'b1;
               end else if (wait_hit) begin
                  fail = 1'b1;
               end else begin
                  wait_count_in = wait_count_ff + 1'b1;
               end
            end
            PH_DELAY: begin
               if (delay_hit) begin
                  bit_index_in = next_index;
                  if (next_index >= twl_pkg::BITS_PER_BYTE) begin
                     phase_in = PH_IDLE;
                     done     = 1'b1;
                  end else begin
                     wait_count_in = '0;
                     phase_in      = is_receive_ff ? PH_RECV_WAIT : PH_SEND_A;
                  end
               end else begin
                  delay_count_in = delay_count_ff + 1'b1;
               end
            end
            default: phase_in = PH_IDLE;
         endcase

         // handshake of one bit complete: shift a sent byte, then delay, next bit or byte done
         if (bit_end) begin
            if (!is_receive_ff) begin
               shift_in = {1'b0, shift_ff[7:1]};
            end
            if (bit_delay_ff != '0) begin
               delay_count_in = '0;
               phase_in       = PH_DELAY;
            end else begin
               bit_index_in = next_index;
               if (next_index >= twl_pkg::BITS_PER_BYTE) begin
                  phase_in = PH_IDLE;
                  done     = 1'b1;
               end else begin
                  wait_count_in = '0;
                  phase_in      = is_receive_ff ? PH_RECV_WAIT : PH_SEND_A;
               end
            end
         end

         if (fail) begin
            phase_in  = PH_IDLE;
            done      = 1'b1;
            err       = is_receive_ff ? twl_pkg::ERR_RECV_TIMEOUT
                                      : twl_pkg::ERR_SEND_TIMEOUT;
            failed_in = !current_last_ff;
         end else if (done && is_receive_ff) begin
            rxb = shift_in;
         end
      end

      // wire drive follows the updated phase
      rsp_in.pull_red_low   = 1'b0;
      rsp_in.pull_white_low = 1'b0;
      if (phase_in == PH_SEND_A) begin
         rsp_in.pull_white_low = shift_in[0];
         rsp_in.pull_red_low   = !shift_in[0];
      end else if (phase_in == PH_RECV_ACK) begin
         rsp_in.pull_red_low   = shift_in[7];
         rsp_in.pull_white_low = !shift_in[7];
      end
      rsp_in.busy_res   = (phase_in != PH_IDLE);
      rsp_in.byte_done  = done;
      rsp_in.rx_byte    = rxb;
      rsp_in.error_code = err;
   end

   // engine state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         is_receive_ff   <= 1'b0;
         shift_ff        <= 8'd0;
         bit_index_ff    <= 4'd0;
         wait_count_ff   <= '0;
         delay_count_ff  <= '0;
         current_last_ff <= 1'b0;
         failed_ff       <= 1'b0;
      end else if (fire) begin
         phase_ff        <= phase_in;
         is_receive_ff   <= is_receive_in;
         shift_ff        <= shift_in;
         bit_index_ff    <= bit_index_in;
         wait_count_ff   <= wait_count_in;
         delay_count_ff  <= delay_count_in;
         current_last_ff <= current_last_in;
         failed_ff       <= failed_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (out_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   `TWL_ASSERT_ALWAYS(a_bit_index_range, clock, reset, bit_index_ff < twl_pkg::BITS_PER_BYTE || phase_ff == PH_IDLE, "bit index past byte while active")
   `TWL_ASSERT_IMPLY(a_error_has_done, clock, reset, rsp_valid_ff && rsp_ff.error_code != twl_pkg::ERR_NONE, rsp_ff.byte_done && !rsp_ff.busy_res, "error reported without byte completion")

endmodule
